/* rtl/assert_macros.svh */
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

/* rtl/fccw_pkg.sv */
// types and constants shared by the fat12 cluster chain walker
package fccw_pkg;

   // sector geometry and walk limits
   localparam int SEC_SIZE     = 512;
   localparam int MAX_SECTORS  = 64;
   localparam int SOFF_W       = $clog2(SEC_SIZE);
   localparam int CNT_W        = SOFF_W + 1;
   localparam int BYTE_W       = 15;
   localparam int NSEC_W       = 7;
   localparam int SKIP_W       = 32 - SOFF_W;
   localparam int MAX_BYTES    = (MAX_SECTORS - 1) * SEC_SIZE;

   // table entry and lba widths
   localparam int CLUS_W  = 12;
   localparam int LIMIT_W = CLUS_W + 1;
   localparam int LBA_W   = 16;

   localparam logic [CLUS_W-1:0] EOC_MARK         = 12'hFF8;
   localparam logic [CLUS_W-1:0] FIRST_CLUSTER    = 12'd2;
   localparam logic [LBA_W-1:0]  DATA_START_RESET = 16'd33;

   // request opcodes
   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_READ  = 2'd1,
      OP_ALLOC = 2'd2,
      OP_NEXT  = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  pair_index;
      logic [7:0]  byte_lo;
      logic [7:0]  byte_mid;
      logic [7:0]  byte_hi;
      logic [CLUS_W-1:0] head_cluster;
      logic [31:0] file_length;
      logic [31:0] read_offset;
      logic [31:0] read_size;
      logic [LBA_W-1:0] query_lba;
   } req_type;

   typedef struct packed {
      logic [LBA_W-1:0]  sector_lba;
      logic [SOFF_W-1:0] sec_offset;
      logic [CNT_W-1:0]  byte_count;
      logic [BYTE_W-1:0] dest_offset;
      logic              last;
      logic [BYTE_W-1:0] total_read;
      logic [CLUS_W-1:0] alloc_cluster;
      logic              status;
   } rsp_type;

   // datapath commands issued by the controller
   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_CLEAR,
      CMD_LOAD_EVEN,
      CMD_LOAD_ODD,
      CMD_SIZE_DIFF,
      CMD_SIZE_MIN,
      CMD_SIZE_CLAMP,
      CMD_SKIP_READ,
      CMD_SKIP_LOAD,
      CMD_WALK_READ,
      CMD_WALK_EMIT,
      CMD_SCAN_READ,
      CMD_SCAN_STEP,
      CMD_CLAIM,
      CMD_NXT_CALC,
      CMD_NXT_READ,
      CMD_NXT_EMIT,
      CMD_EMPTY
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type code;
      logic       fail;
   } ctl_cmd_type;

   typedef struct packed {
      logic empty;
      logic skip_big;
      logic skip_zero;
      logic cur_usable;
      logic walk_last;
      logic free_hit;
      logic scan_end;
      logic clear_end;
      logic nxt_hit;
   } dp_status_type;

endpackage

/* rtl/fccw_ram.sv */
// generic single write port ram with registered read
module fccw_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/fccw_dpath.sv */
// datapath: allocation table, walk arithmetic and result register
module fccw_dpath
   import fccw_pkg::*;
#(
   parameter int TABLE_ENTRIES = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_data,
   input  logic             csr_wr_en,
   input  logic [LBA_W-1:0] csr_data,
   input  ctl_cmd_type      cmd,
   output dp_status_type    status,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam logic [LIMIT_W-1:0] TABLE_LIMIT = LIMIT_W'(TABLE_ENTRIES);

   // cluster can be followed: in range and not an end mark
   function automatic logic usable(input logic [CLUS_W-1:0] c);
      usable = (c >= FIRST_CLUSTER) && ({1'b0, c} < TABLE_LIMIT) && (c < EOC_MARK);
   endfunction

   req_type           in_ff, in_in;
   logic [LBA_W-1:0]  dsl_ff, dsl_in;
   logic [31:0]       diff_ff, diff_in;
   logic [BYTE_W-1:0] size_ff, size_in;
   logic              empty_ff, empty_in;
   logic              big_ff, big_in;
   logic              hit_ff, hit_in;
   logic [CLUS_W-1:0] cur_ff, cur_in;
   logic [AW-1:0]     skip_ff, skip_in;
   logic [SOFF_W-1:0] soff_ff, soff_in;
   logic [BYTE_W-1:0] done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NSEC_W-1:0] n_ff, n_in;
   logic [LIMIT_W-1:0] scan_ff, scan_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [CLUS_W-1:0] ram_wdata, ram_rdata;

   logic [LIMIT_W-1:0] even_idx, odd_idx;
   logic [32:0]        len_minus_off;
   logic               past_end;
   logic [SKIP_W-1:0]  skip_sectors;
   logic               skip_big;
   logic [CNT_W-1:0]   room;
   logic [BYTE_W-1:0]  remain;
   logic [CNT_W-1:0]   step_cnt;
   logic [BYTE_W-1:0]  total;
   logic               walk_fin, next_bad;
   logic [LBA_W-1:0]   lba_cur, lba_next;
   logic [LBA_W:0]     q_minus;
   logic [LBA_W:0]     q_clus;
   logic               q_hit;

   // allocation table
   fccw_ram #(
      .WIDTH (CLUS_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // pair load addresses
   assign even_idx = {{(LIMIT_W - 9){1'b0}}, in_ff.pair_index, 1'b0};
   assign odd_idx  = even_idx | LIMIT_W'(1);

   // read size setup
   assign len_minus_off = {1'b0, in_ff.file_length} - {1'b0, in_ff.read_offset};
   assign past_end      = len_minus_off[32] || (len_minus_off[31:0] == '0) ||
                          (in_ff.read_size == '0);
   assign skip_sectors  = in_ff.read_offset[31:SOFF_W];
   assign skip_big      = skip_sectors >= SKIP_W'(TABLE_ENTRIES);

   // per sector byte count
   assign room     = CNT_W'(SEC_SIZE) - {1'b0, soff_ff};
   assign remain   = size_ff - done_ff;
   assign step_cnt = (remain < BYTE_W'(room)) ? remain[CNT_W-1:0] : room;

   // descriptor end conditions
   assign total    = done_ff + BYTE_W'(cnt_ff);
   assign walk_fin = (total >= size_ff) || (n_ff == NSEC_W'(MAX_SECTORS - 1));
   assign next_bad = !usable(ram_rdata);

   // cluster to lba
   assign lba_cur  = dsl_ff + LBA_W'(cur_ff) - LBA_W'(FIRST_CLUSTER);
   assign lba_next = dsl_ff + LBA_W'(ram_rdata) - LBA_W'(FIRST_CLUSTER);

   // lba to cluster for the successor query
   assign q_minus = {1'b0, in_ff.query_lba} - {1'b0, dsl_ff};
   assign q_clus  = {1'b0, q_minus[LBA_W-1:0]} + (LBA_W + 1)'(FIRST_CLUSTER);
   assign q_hit   = !q_minus[LBA_W] && (q_clus < (LBA_W + 1)'(TABLE_LIMIT));

   // table port selection
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = scan_ff[AW-1:0];
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = cur_ff[AW-1:0];
      case (cmd.code)
         CMD_CLEAR: begin
            ram_we = 1'b1;
         end
         CMD_LOAD_EVEN: begin
            ram_we    = even_idx < TABLE_LIMIT;
            ram_waddr = even_idx[AW-1:0];
            ram_wdata = {in_ff.byte_mid[3:0], in_ff.byte_lo};
         end
         CMD_LOAD_ODD: begin
            ram_we    = odd_idx < TABLE_LIMIT;
            ram_waddr = odd_idx[AW-1:0];
            ram_wdata = {in_ff.byte_hi, in_ff.byte_mid[7:4]};
         end
         CMD_CLAIM: begin
            ram_we    = 1'b1;
            ram_wdata = EOC_MARK;
         end
         CMD_SKIP_READ, CMD_WALK_READ, CMD_NXT_READ: begin
            ram_re = 1'b1;
         end
         CMD_SCAN_READ: begin
            ram_re    = 1'b1;
            ram_raddr = scan_ff[AW-1:0];
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // next state of the working registers
   always_comb begin
      in_in        = in_ff;
      dsl_in       = csr_wr_en ? csr_data : dsl_ff;
      diff_in      = diff_ff;
      size_in      = size_ff;
      empty_in     = empty_ff;
      big_in       = big_ff;
      hit_in       = hit_ff;
      cur_in       = cur_ff;
      skip_in      = skip_ff;
      soff_in      = soff_ff;
      done_in      = done_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      scan_in      = scan_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      case (cmd.code)
         CMD_CAPTURE: begin
            in_in   = req_data;
            scan_in = LIMIT_W'(FIRST_CLUSTER);
         end
         CMD_CLEAR, CMD_SCAN_STEP: begin
            scan_in = scan_ff + LIMIT_W'(1);
         end
         CMD_SIZE_DIFF: begin
            diff_in  = len_minus_off[31:0];
            empty_in = past_end;
            big_in   = skip_big;
         end
         CMD_SIZE_MIN: begin
            diff_in = (in_ff.read_size < diff_ff) ? in_ff.read_size : diff_ff;
         end
         CMD_SIZE_CLAMP: begin
            size_in = (diff_ff > 32'(MAX_BYTES)) ? BYTE_W'(MAX_BYTES)
                                                 : diff_ff[BYTE_W-1:0];
            cur_in  = in_ff.head_cluster;
            skip_in = in_ff.read_offset[SOFF_W +: AW];
            soff_in = in_ff.read_offset[SOFF_W-1:0];
            done_in = '0;
            n_in    = '0;
         end
         CMD_SKIP_READ: begin
            skip_in = skip_ff - AW'(1);
         end
         CMD_SKIP_LOAD: begin
            cur_in = ram_rdata;
         end
         CMD_WALK_READ: begin
            cnt_in = step_cnt;
         end
         CMD_WALK_EMIT: begin
            rsp_valid_in         = 1'b1;
            rsp_in               = '0;
            rsp_in.sector_lba    = lba_cur;
            rsp_in.sec_offset    = soff_ff;
            rsp_in.byte_count    = cnt_ff;
            rsp_in.dest_offset   = done_ff;
            rsp_in.total_read    = total;
            rsp_in.last          = walk_fin || next_bad;
            rsp_in.status        = !walk_fin && next_bad;
            done_in = total;
            n_in    = n_ff + NSEC_W'(1);
            soff_in = '0;
            cur_in  = ram_rdata;
         end
         CMD_CLAIM: begin
            rsp_valid_in         = 1'b1;
            rsp_in               = '0;
            rsp_in.alloc_cluster = scan_ff[CLUS_W-1:0];
            rsp_in.last          = 1'b1;
         end
         CMD_NXT_CALC: begin
            cur_in = q_clus[CLUS_W-1:0];
            hit_in = q_hit;
         end
         CMD_NXT_EMIT: begin
            rsp_valid_in      = 1'b1;
            rsp_in            = '0;
            rsp_in.sector_lba = usable(ram_rdata) ? lba_next : '0;
            rsp_in.last       = 1'b1;
         end
         CMD_EMPTY: begin
            rsp_valid_in  = 1'b1;
            rsp_in        = '0;
            rsp_in.last   = 1'b1;
            rsp_in.status = cmd.fail;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dsl_ff       <= DATA_START_RESET;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dsl_ff       <= dsl_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_ff    <= in_in;
      diff_ff  <= diff_in;
      size_ff  <= size_in;
      empty_ff <= empty_in;
      big_ff   <= big_in;
      hit_ff   <= hit_in;
      cur_ff   <= cur_in;
      skip_ff  <= skip_in;
      soff_ff  <= soff_in;
      done_ff  <= done_in;
      cnt_ff   <= cnt_in;
      n_ff     <= n_in;
      rsp_ff   <= rsp_in;
   end

   // status back to the controller
   always_comb begin
      status.empty      = empty_ff;
      status.skip_big   = big_ff;
      status.skip_zero  = (skip_ff == '0);
      status.cur_usable = usable(cur_ff);
      status.walk_last  = walk_fin || next_bad;
      status.free_hit   = (ram_rdata == '0);
      status.scan_end   = scan_ff >= TABLE_LIMIT;
      status.clear_end  = scan_ff == LIMIT_W'(TABLE_ENTRIES - 1);
      status.nxt_hit    = hit_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/fccw_ctrl.sv */
// controller: sequences table clear, pair load, chain walk, allocation and lookup
module fccw_ctrl
   import fccw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  op_type        req_op,
   input  dp_status_type status,
   output logic          busy,
   output ctl_cmd_type   cmd
);

   typedef enum logic [15:0] {
      S_IDLE      = 16'h0001,
      S_CLEAR     = 16'h0002,
      S_LOAD_EVEN = 16'h0004,
      S_LOAD_ODD  = 16'h0008,
      S_DIFF      = 16'h0010,
      S_MIN       = 16'h0020,
      S_CLAMP     = 16'h0040,
      S_SKIP      = 16'h0080,
      S_SKIP_WAIT = 16'h0100,
      S_WALK_READ = 16'h0200,
      S_WALK_EMIT = 16'h0400,
      S_SCAN      = 16'h0800,
      S_SCAN_EVAL = 16'h1000,
      S_NXT_CALC  = 16'h2000,
      S_NXT_READ  = 16'h4000,
      S_NXT_EVAL  = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   // next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd.code = CMD_NONE;
      cmd.fail = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.code = CMD_CAPTURE;
               unique case (req_op)
                  OP_LOAD:  state_in = S_LOAD_EVEN;
                  OP_READ:  state_in = S_DIFF;
                  OP_ALLOC: state_in = S_SCAN;
                  OP_NEXT:  state_in = S_NXT_CALC;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         // clearing pass after reset, one entry a cycle
         S_CLEAR: begin
            cmd.code = CMD_CLEAR;
            if (status.clear_end) begin
               state_in = S_IDLE;
            end
         end
         S_LOAD_EVEN: begin
            cmd.code = CMD_LOAD_EVEN;
            state_in = S_LOAD_ODD;
         end
         S_LOAD_ODD: begin
            cmd.code = CMD_LOAD_ODD;
            state_in = S_IDLE;
         end
         // size setup
         S_DIFF: begin
            cmd.code = CMD_SIZE_DIFF;
            state_in = S_MIN;
         end
         S_MIN: begin
            if (status.empty) begin
               cmd.code = CMD_EMPTY;
               state_in = S_IDLE;
            end else begin
               cmd.code = CMD_SIZE_MIN;
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            if (status.skip_big) begin
               cmd.code = CMD_EMPTY;
               cmd.fail = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.code = CMD_SIZE_CLAMP;
               state_in = S_SKIP;
            end
         end
         // skip whole sectors ahead of the offset
         S_SKIP: begin
            if (!status.cur_usable) begin
               cmd.code = CMD_EMPTY;
               cmd.fail = 1'b1;
               state_in = S_IDLE;
            end else if (status.skip_zero) begin
               cmd.code = CMD_WALK_READ;
               state_in = S_WALK_EMIT;
            end else begin
               cmd.code = CMD_SKIP_READ;
               state_in = S_SKIP_WAIT;
            end
         end
         S_SKIP_WAIT: begin
            cmd.code = CMD_SKIP_LOAD;
            state_in = S_SKIP;
         end
         // one descriptor per sector
         S_WALK_READ: begin
            cmd.code = CMD_WALK_READ;
            state_in = S_WALK_EMIT;
         end
         S_WALK_EMIT: begin
            cmd.code = CMD_WALK_EMIT;
            state_in = status.walk_last ? S_IDLE : S_WALK_READ;
         end
         // free entry search
         S_SCAN: begin
            if (status.scan_end) begin
               cmd.code = CMD_EMPTY;
               cmd.fail = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.code = CMD_SCAN_READ;
               state_in = S_SCAN_EVAL;
            end
         end
         S_SCAN_EVAL: begin
            if (status.free_hit) begin
               cmd.code = CMD_CLAIM;
               state_in = S_IDLE;
            end else begin
               cmd.code = CMD_SCAN_STEP;
               state_in = S_SCAN;
            end
         end
         // successor sector lookup
         S_NXT_CALC: begin
            cmd.code = CMD_NXT_CALC;
            state_in = S_NXT_READ;
         end
         S_NXT_READ: begin
            if (status.nxt_hit) begin
               cmd.code = CMD_NXT_READ;
               state_in = S_NXT_EVAL;
            end else begin
               cmd.code = CMD_EMPTY;
               state_in = S_IDLE;
            end
         end
         S_NXT_EVAL: begin
            cmd.code = CMD_NXT_EMIT;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* rtl/fat12_cluster_chain_walker.sv */
// top level of the fat12 cluster chain walker
//
//  channel  ports                        transfer rule
//  request  start, busy, req_data        start high while busy low
//  result   rsp_valid, rsp_data          one cycle strobe, always taken
//  csr      csr_valid, csr_ready, csr_data  valid and ready both high
//
// after reset the table is cleared one entry a cycle, busy high; load writes the even then
// the odd entry; next sector lookup maps the lba to a cluster and reads its entry on a hit
// read does its setup, then a table read and load per skipped sector and a read and emit per
// descriptor, one table read per cluster on the single read port; an empty read ends in setup
// allocate reads and tests each table entry in turn, from entry two upward, failing when full
// results leave one per strobe and cannot be stalled; csr writes are taken at any time
`include "assert_macros.svh"

module fat12_cluster_chain_walker
   import fccw_pkg::*;
#(
   parameter int TABLE_ENTRIES = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LBA_W-1:0] csr_data
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   // register port always open
   assign csr_ready = 1'b1;

   // controller
   fccw_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_data.op),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // datapath
   fccw_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr_en (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // an accepted request keeps the block busy in the next cycle
   `ASSERT_CLK(a_accept_busy, clock, reset, start && !busy |=> busy, "accepted request not busy")
   // a result only follows a cycle of work
   `ASSERT_CLK(a_rsp_after_work, clock, reset, rsp_valid |-> $past(busy), "result from idle")
   // only the final result of a request frees the block
   `ASSERT_NEVER(a_last_frees, clock, reset, rsp_valid && (busy == rsp_data.last), "last mismatch")

endmodule
